// ----- sv/assert_macros.svh -----
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/lcrc_pkg.sv -----
// Types and constants of the launch clutch ramp controller.
`default_nettype none
package lcrc_pkg;

	typedef enum logic [2:0] {
		MODE_OFF           = 3'd0,
		MODE_START         = 3'd1,
		MODE_READY         = 3'd2,
		MODE_START_RELEASE = 3'd3,
		MODE_RELEASING     = 3'd4,
		MODE_RUNNING       = 3'd5,
		MODE_STOPPING      = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_START   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MSG_NONE  = 2'd0,
		MSG_READY = 2'd1,
		MSG_OFF   = 2'd2
	} msg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV_Q,
		ST_WRITE
	} seq_state_t;

	localparam logic [2:0] CFG_START_LEVEL = 3'd0;
	localparam logic [2:0] CFG_END_LEVEL   = 3'd1;
	localparam logic [2:0] CFG_DURATION    = 3'd2;
	localparam logic [2:0] CFG_G1_RPM      = 3'd3;
	localparam logic [2:0] CFG_G1_SPEED    = 3'd4;
	localparam logic [2:0] CFG_G3_RPM      = 3'd5;
	localparam logic [2:0] CFG_G3_SPEED    = 3'd6;

	localparam logic [6:0]  FULL_LEVEL = 7'd100;
	localparam logic [15:0] FULL_FIXED = 16'd25600;
	localparam logic [2:0]  STOP_GEAR  = 3'd2;
	localparam logic [2:0]  GEAR_ONE   = 3'd1;
	localparam logic [2:0]  GEAR_THREE = 3'd3;

	localparam int LEVEL_W = 7;
	localparam int DUR_W   = 14;
	localparam int RPM_W   = 14;
	localparam int SPD_W   = 10;
	localparam int FRAC_W  = 8;

endpackage
`default_nettype wire

// ----- sv/launch_clutch_ramp_controller_core.sv -----
// Launch clutch ramp sequencer with a serial restoring divider for the ramp set-up.
// Each request passes ST_EXEC, then ST_WRITE, which loads it once the output slot is free.
// The ramp set-up tick runs the serial divider once, one quotient bit a cycle,
//   in ST_DIV_Q, between ST_EXEC and ST_WRITE.
// One item at a time; the next request is taken once the result is in the output register.
// Reset (async, active low) clears mode, ramp state and output valid; config registers take defaults.
`default_nettype none
`include "assert_macros.svh"
module launch_clutch_ramp_controller_core
	import lcrc_pkg::*;
#(
	parameter int TICK_PERIOD_MS = 10
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [13:0]  cfg_data,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   action,
	input  wire logic [13:0]  engine_rpm,
	input  wire logic [9:0]   road_speed,
	input  wire logic [2:0]   current_gear,
	input  wire logic [6:0]   measured_clutch,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              clutch_write,
	output logic [6:0]        clutch_command,
	output logic              limiter_engage,
	output logic              limiter_release,
	output logic              upshift_request,
	output logic [1:0]        bus_message,
	output logic              beep,
	output logic [2:0]        mode
);

	localparam int TICK_W = $clog2(TICK_PERIOD_MS + 1);
	localparam int PROD_W = LEVEL_W + TICK_W;
	localparam int NUM_W  = PROD_W + FRAC_W;
	localparam int CNT_W  = $clog2(NUM_W);

	// tick budget by reciprocal multiplication, exact over the duration range
	localparam int RECIP_SH = DUR_W + $clog2(TICK_PERIOD_MS);
	localparam int RECIP    = ((1 << RECIP_SH) + TICK_PERIOD_MS - 1) / TICK_PERIOD_MS;
	localparam int TPROD_W  = RECIP_SH + DUR_W;

	// configuration
	logic [LEVEL_W-1:0] start_lvl_q, end_lvl_q;
	logic [DUR_W-1:0]   dur_q;
	logic [RPM_W-1:0]   g1_rpm_q, g3_rpm_q;
	logic [SPD_W-1:0]   g1_spd_q, g3_spd_q;

	// sequencer and model state
	seq_state_t  state_q, state_d;
	mode_t       mode_q, mode_d;
	logic [15:0] level_q, level_d;
	logic [14:0] step_mag_q, step_mag_d;
	logic        step_neg_q, step_neg_d;
	logic [13:0] ticks_q, ticks_d;

	// latched request
	action_t            act_q;
	logic [RPM_W-1:0]   rpm_q;
	logic [SPD_W-1:0]   spd_q;
	logic [2:0]         gear_q;
	logic [LEVEL_W-1:0] meas_q;

	// serial divider
	logic [NUM_W-1:0] dvd_q, dvd_d;
	logic [DUR_W-1:0] dvs_q, dvs_d;
	logic [DUR_W-1:0] rem_q, rem_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [14:0]      res_step_q, res_step_d;
	logic [13:0]      res_ticks_q, res_ticks_d;
	logic [DUR_W:0]   trial, diff;
	logic             qbit;
	logic [NUM_W-1:0] quot;
	logic [TPROD_W-1:0] ticks_prod;

	// result register
	logic        ov_q;
	logic        cw_q, leng_q, lrel_q, up_q, beep_q;
	logic [6:0]  cmd_q;
	msg_t        msg_q;
	mode_t       mode_out_q;
	logic        load;
	logic        o_cw, o_leng, o_lrel, o_up, o_beep;
	logic [6:0]  o_cmd;
	msg_t        o_msg;

	logic [LEVEL_W-1:0] start_c, end_c, mag;
	logic [PROD_W-1:0]  prod;
	logic [16:0]        sum_up;
	logic [15:0]        lvl_new;
	logic               done;
	logic               slot_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign slot_free = !ov_q || !out_stall;

	assign start_c = (start_lvl_q > FULL_LEVEL) ? FULL_LEVEL : start_lvl_q;
	assign end_c   = (end_lvl_q > FULL_LEVEL) ? FULL_LEVEL : end_lvl_q;
	assign mag     = (start_c >= end_c) ? (start_c - end_c) : (end_c - start_c);
	assign prod    = PROD_W'(mag) * PROD_W'(TICK_PERIOD_MS);

	assign ticks_prod = TPROD_W'(dur_q) * TPROD_W'(RECIP);

	assign trial = {rem_q, dvd_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});
	assign quot  = {dvd_q[NUM_W-2:0], qbit};

	assign sum_up = {1'b0, level_q} + {2'b00, step_mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_lvl_q <= 7'd100;
			end_lvl_q   <= 7'd0;
			dur_q       <= 14'd500;
			g1_rpm_q    <= '0;
			g1_spd_q    <= '0;
			g3_rpm_q    <= '0;
			g3_spd_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_LEVEL: start_lvl_q <= cfg_data[LEVEL_W-1:0];
				CFG_END_LEVEL:   end_lvl_q   <= cfg_data[LEVEL_W-1:0];
				CFG_DURATION:    dur_q       <= cfg_data[DUR_W-1:0];
				CFG_G1_RPM:      g1_rpm_q    <= cfg_data[RPM_W-1:0];
				CFG_G1_SPEED:    g1_spd_q    <= cfg_data[SPD_W-1:0];
				CFG_G3_RPM:      g3_rpm_q    <= cfg_data[RPM_W-1:0];
				CFG_G3_SPEED:    g3_spd_q    <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			act_q  <= action_t'(action);
			rpm_q  <= engine_rpm;
			spd_q  <= road_speed;
			gear_q <= current_gear;
			meas_q <= measured_clutch;
		end
		dvd_q       <= dvd_d;
		dvs_q       <= dvs_d;
		rem_q       <= rem_d;
		cnt_q       <= cnt_d;
		res_step_q  <= res_step_d;
		res_ticks_q <= res_ticks_d;
		if (load) begin
			cw_q       <= o_cw;
			cmd_q      <= o_cmd;
			leng_q     <= o_leng;
			lrel_q     <= o_lrel;
			up_q       <= o_up;
			msg_q      <= o_msg;
			beep_q     <= o_beep;
			mode_out_q <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_OFF;
			level_q    <= '0;
			step_mag_q <= '0;
			step_neg_q <= 1'b0;
			ticks_q    <= '0;
			ov_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			level_q    <= level_d;
			step_mag_q <= step_mag_d;
			step_neg_q <= step_neg_d;
			ticks_q    <= ticks_d;
			if (load)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		level_d     = level_q;
		step_mag_d  = step_mag_q;
		step_neg_d  = step_neg_q;
		ticks_d     = ticks_q;
		dvd_d       = dvd_q;
		dvs_d       = dvs_q;
		rem_d       = rem_q;
		cnt_d       = cnt_q;
		res_step_d  = res_step_q;
		res_ticks_d = res_ticks_q;
		load        = 1'b0;
		o_cw        = 1'b0;
		o_cmd       = '0;
		o_leng      = 1'b0;
		o_lrel      = 1'b0;
		o_up        = 1'b0;
		o_msg       = MSG_NONE;
		o_beep      = 1'b0;
		lvl_new     = level_q;
		done        = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				res_step_d  = '0;
				res_ticks_d = ticks_prod[TPROD_W-1 -: DUR_W];
				if (act_q == ACT_TICK && mode_q == MODE_START_RELEASE && dur_q != '0) begin
					dvd_d   = {prod, {FRAC_W{1'b0}}};
					dvs_d   = dur_q;
					rem_d   = '0;
					cnt_d   = CNT_W'(NUM_W - 1);
					state_d = ST_DIV_Q;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_DIV_Q: begin
				dvd_d = quot;
				rem_d = qbit ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					res_step_d = (quot > NUM_W'(FULL_FIXED)) ? 15'(FULL_FIXED) : quot[14:0];
					state_d    = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (slot_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
					case (act_q)
						ACT_START: begin
							if (mode_q == MODE_OFF)
								mode_d = MODE_START;
						end
						ACT_RELEASE: begin
							if (mode_q == MODE_READY)
								mode_d = MODE_START_RELEASE;
						end
						ACT_STOP: begin
							if (mode_q != MODE_OFF)
								mode_d = MODE_STOPPING;
						end
						ACT_TICK: begin
							case (mode_q)
								MODE_START: begin
									o_leng  = 1'b1;
									o_msg   = MSG_READY;
									level_d = FULL_FIXED;
									o_cw    = 1'b1;
									o_cmd   = FULL_LEVEL;
									mode_d  = MODE_READY;
								end
								MODE_READY: begin
									o_cw  = 1'b1;
									o_cmd = FULL_LEVEL;
								end
								MODE_START_RELEASE: begin
									level_d    = {1'b0, start_c, {FRAC_W{1'b0}}};
									o_cw       = 1'b1;
									o_cmd      = start_c;
									ticks_d    = res_ticks_q;
									step_mag_d = res_step_q;
									step_neg_d = (start_c < end_c);
									mode_d     = MODE_RELEASING;
								end
								MODE_RELEASING: begin
									if (step_neg_q)
										lvl_new = (sum_up > {1'b0, FULL_FIXED}) ?
											FULL_FIXED : sum_up[15:0];
									else
										lvl_new = (level_q > {1'b0, step_mag_q}) ?
											(level_q - {1'b0, step_mag_q}) : '0;
									level_d = lvl_new;
									done    = (ticks_q <= 14'd1) || (meas_q <= end_c);
									if (ticks_q != '0)
										ticks_d = ticks_q - 1'b1;
									o_cw   = 1'b1;
									o_cmd  = done ? 7'd0 : lvl_new[14:8];
									o_beep = 1'b1;
									if (done) begin
										o_lrel = 1'b1;
										mode_d = MODE_RUNNING;
									end
								end
								MODE_RUNNING: begin
									if (gear_q == STOP_GEAR)
										mode_d = MODE_STOPPING;
									else if (gear_q == GEAR_ONE)
										o_up = (rpm_q >= g1_rpm_q) && (spd_q >= g1_spd_q);
									else if (gear_q == GEAR_THREE)
										o_up = (rpm_q >= g3_rpm_q) && (spd_q >= g3_spd_q);
								end
								MODE_STOPPING: begin
									mode_d = MODE_OFF;
									o_msg  = MSG_OFF;
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid       = ov_q;
	assign clutch_write    = cw_q;
	assign clutch_command  = cmd_q;
	assign limiter_engage  = leng_q;
	assign limiter_release = lrel_q;
	assign upshift_request = up_q;
	assign bus_message     = msg_q;
	assign beep            = beep_q;
	assign mode            = mode_out_q;

	`ASSERT_ALWAYS(a_level_in_range, clk, arst_n, level_q <= FULL_FIXED)
	`ASSERT_ALWAYS(a_step_in_range, clk, arst_n, step_mag_q <= 15'(FULL_FIXED))
	`ASSERT_NEXT(a_div_hands_over, clk, arst_n, state_q == ST_DIV_Q && cnt_q == '0, state_q == ST_WRITE)
	`ASSERT_NEXT(a_write_loads, clk, arst_n, state_q == ST_WRITE && slot_free, ov_q && state_q == ST_IDLE)
	`ASSERT_IMPL(a_cmd_needs_write, clk, arst_n, ov_q && !cw_q, cmd_q == 7'd0)

endmodule
`default_nettype wire
